// ----- rtl/core/hrcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types and constants of the HTTP response chunk decoder.
// ----------------------------------------------------------------------------
package hrcd_pkg;

    localparam int CHUNK_SIZE_BITS_DEF = 32;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BODY = 2'd0;
    localparam kind_t KIND_DONE = 2'd1;
    localparam kind_t KIND_FAIL = 2'd2;

    localparam logic [9:0] STATUS_MAX = 10'd999;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_C  = 8'h63;

    // last index of the word "chunked"
    localparam logic [2:0] WORD_LAST = 3'd6;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [9:0] resp_status;
        logic       last;
    } result_t;

    // characters of "chunked"
    function automatic logic [7:0] word_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h68;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h6B;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/hrcd_if.sv -----
// ----------------------------------------------------------------------------
// hrcd_if
// Valid/ready channels of the HTTP response chunk decoder.
// ----------------------------------------------------------------------------
interface hrcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_response;

    modport source (output valid, output in_byte, output end_of_response, input ready);
    modport sink   (input valid, input in_byte, input end_of_response, output ready);
endinterface

interface hrcd_out_if;
    logic               valid;
    logic               ready;
    hrcd_pkg::kind_t    kind;
    logic [7:0]         out_byte;
    logic [9:0]         resp_status;
    logic               last;

    modport source (output valid, output kind, output out_byte, output resp_status,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input resp_status,
                    input last, output ready);
endinterface

// ----- rtl/core/http_response_chunk_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// http_response_chunk_decoder_unit
// Byte-serial HTTP/1.1 response parser with chunked transfer decoding.
// ----------------------------------------------------------------------------
// One response byte is taken per beat, one per cycle while the four-entry
// result queue has room for two results. Each byte updates the registered
// parser state; a body byte and, on end_of_response, a done/fail beat
// carrying the status code are queued, so one byte may yield two results.
// Results drain one per cycle while the output side is ready. The status
// code saturates at 999; chunk sizes saturate at CHUNK_SIZE_BITS ones.
// No clearing pass after reset.
module http_response_chunk_decoder_unit #(
    parameter int CHUNK_SIZE_BITS = hrcd_pkg::CHUNK_SIZE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hrcd_in_if.sink     data,
    hrcd_out_if.source  result
);

    typedef enum logic [11:0] {
        PH_STATUS_START  = 12'b0000_0000_0001,
        PH_STATUS_DIGITS = 12'b0000_0000_0010,
        PH_HEADER        = 12'b0000_0000_0100,
        PH_BODY          = 12'b0000_0000_1000,
        PH_SIZE_START    = 12'b0000_0001_0000,
        PH_SIZE_DIGITS   = 12'b0000_0010_0000,
        PH_SIZE_EXT      = 12'b0000_0100_0000,
        PH_SIZE_LF       = 12'b0000_1000_0000,
        PH_DATA          = 12'b0001_0000_0000,
        PH_DATA_CR       = 12'b0010_0000_0000,
        PH_DATA_LF       = 12'b0100_0000_0000,
        PH_DONE          = 12'b1000_0000_0000
    } phase_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    phase_t                       phase_reg, phase_next;
    logic [9:0]                   status_reg, status_next;
    logic [2:0]                   match_pos_reg, match_pos_next;
    logic                         is_chunked_reg, is_chunked_next;
    logic [1:0]                   crlf_reg, crlf_next;
    logic [CHUNK_SIZE_BITS-1:0]   remaining_reg, remaining_next;
    logic                         failed_reg, failed_next;

    hrcd_pkg::result_t            q_reg [QDEPTH];
    logic [QAW-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]                 count_reg;

    logic        in_acc, out_acc;
    logic [7:0]  b;
    logic        header_ended;
    logic        body_valid;
    logic        is_digit;
    logic [13:0] status_sum;
    logic [4:0]  hex_val;
    logic        ok;
    logic [1:0]  push_n;
    hrcd_pkg::result_t body_res, final_res, first_res;

    assign b       = data.in_byte;
    assign in_acc  = data.valid && data.ready;
    assign out_acc = result.valid && result.ready;

    // room for two results regardless of the output side
    assign data.ready = (count_reg <= (QAW+1)'(QDEPTH - 2));

    assign is_digit   = (b >= hrcd_pkg::CHAR_ZERO) && (b <= hrcd_pkg::CHAR_NINE);
    assign status_sum = {1'b0, status_reg, 3'b000} + {3'b000, status_reg, 1'b0}
                        + {10'd0, 4'(b - hrcd_pkg::CHAR_ZERO)};

    // hex digit value, bit 4 set when the byte is no hex digit
    always_comb
    begin
        if (is_digit)
            hex_val = {1'b0, 4'(b - hrcd_pkg::CHAR_ZERO)};
        else if (b >= hrcd_pkg::CHAR_LC_A && b <= hrcd_pkg::CHAR_LC_F)
            hex_val = {1'b0, 4'(b - hrcd_pkg::CHAR_LC_A + 8'd10)};
        else if (b >= hrcd_pkg::CHAR_UC_A && b <= hrcd_pkg::CHAR_UC_F)
            hex_val = {1'b0, 4'(b - hrcd_pkg::CHAR_UC_A + 8'd10)};
        else
            hex_val = 5'h10;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        status_next     = status_reg;
        match_pos_next  = match_pos_reg;
        is_chunked_next = is_chunked_reg;
        crlf_next       = crlf_reg;
        remaining_next  = remaining_reg;
        failed_next     = failed_reg;
        header_ended    = 1'b0;
        body_valid      = 1'b0;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_STATUS_START, PH_STATUS_DIGITS, PH_HEADER:
                begin
                    // "chunked" scan over status line and header
                    if (b == hrcd_pkg::word_char(match_pos_reg))
                    begin
                        if (match_pos_reg == hrcd_pkg::WORD_LAST)
                        begin
                            is_chunked_next = 1'b1;
                            match_pos_next  = 3'd0;
                        end
                        else
                            match_pos_next = match_pos_reg + 3'd1;
                    end
                    else
                        match_pos_next = (b == hrcd_pkg::CHAR_LC_C) ? 3'd1 : 3'd0;

                    // blank line: CR LF CR LF
                    if (b == hrcd_pkg::CHAR_CR)
                        crlf_next = (crlf_reg == 2'd2) ? 2'd3 : 2'd1;
                    else if (b == hrcd_pkg::CHAR_LF)
                    begin
                        if (crlf_reg == 2'd3)
                        begin
                            crlf_next    = 2'd0;
                            header_ended = 1'b1;
                        end
                        else
                            crlf_next = (crlf_reg == 2'd1) ? 2'd2 : 2'd0;
                    end
                    else
                        crlf_next = 2'd0;

                    if (phase_reg == PH_STATUS_START)
                    begin
                        if (b == hrcd_pkg::CHAR_SPACE)
                            phase_next = PH_STATUS_DIGITS;
                        else if (b == hrcd_pkg::CHAR_CR || b == hrcd_pkg::CHAR_LF)
                            phase_next = PH_HEADER;
                    end
                    else if (phase_reg == PH_STATUS_DIGITS)
                    begin
                        if (is_digit)
                            status_next = (status_sum > {4'd0, hrcd_pkg::STATUS_MAX})
                                          ? hrcd_pkg::STATUS_MAX : status_sum[9:0];
                        else
                            phase_next = PH_HEADER;
                    end

                    if (header_ended)
                        phase_next = is_chunked_next ? PH_SIZE_START : PH_BODY;
                end
                PH_BODY:
                    body_valid = 1'b1;
                PH_SIZE_START, PH_SIZE_DIGITS:
                begin
                    if (b == hrcd_pkg::CHAR_CR)
                        phase_next = PH_SIZE_LF;
                    else if (!hex_val[4])
                    begin
                        if (remaining_reg[CHUNK_SIZE_BITS-1 -: 4] != 4'd0)
                            remaining_next = '1;
                        else
                            remaining_next = {remaining_reg[CHUNK_SIZE_BITS-5:0], hex_val[3:0]};
                        phase_next = PH_SIZE_DIGITS;
                    end
                    else
                        phase_next = PH_SIZE_EXT;
                end
                PH_SIZE_EXT:
                    if (b == hrcd_pkg::CHAR_CR)
                        phase_next = PH_SIZE_LF;
                PH_SIZE_LF:
                begin
                    if (b != hrcd_pkg::CHAR_LF)
                        failed_next = 1'b1;
                    else
                        phase_next = (remaining_reg == '0) ? PH_DONE : PH_DATA;
                end
                PH_DATA:
                begin
                    body_valid     = 1'b1;
                    remaining_next = remaining_reg - CHUNK_SIZE_BITS'(1);
                    if (remaining_next == '0)
                        phase_next = PH_DATA_CR;
                end
                PH_DATA_CR:
                begin
                    if (b != hrcd_pkg::CHAR_CR)
                        failed_next = 1'b1;
                    else
                        phase_next = PH_DATA_LF;
                end
                PH_DATA_LF:
                begin
                    if (b != hrcd_pkg::CHAR_LF)
                        failed_next = 1'b1;
                    else
                    begin
                        phase_next     = PH_SIZE_START;
                        remaining_next = '0;
                    end
                end
                PH_DONE:
                    ;
                default:
                    ;
            endcase
        end
    end

    // outcome judged on the state after this byte
    assign ok = !failed_next &&
                (phase_next == PH_STATUS_START || phase_next == PH_STATUS_DIGITS ||
                 phase_next == PH_HEADER || phase_next == PH_BODY ||
                 phase_next == PH_SIZE_START || phase_next == PH_DONE);

    always_comb
    begin
        body_res.kind        = hrcd_pkg::KIND_BODY;
        body_res.out_byte    = b;
        body_res.resp_status = 10'd0;
        body_res.last        = 1'b0;

        final_res.kind        = ok ? hrcd_pkg::KIND_DONE : hrcd_pkg::KIND_FAIL;
        final_res.out_byte    = 8'd0;
        final_res.resp_status = status_next;
        final_res.last        = 1'b1;

        first_res = body_valid ? body_res : final_res;
        push_n    = in_acc ? ({1'b0, body_valid} + {1'b0, data.end_of_response}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STATUS_START;
            status_reg     <= 10'd0;
            match_pos_reg  <= 3'd0;
            is_chunked_reg <= 1'b0;
            crlf_reg       <= 2'd0;
            remaining_reg  <= '0;
            failed_reg     <= 1'b0;
        end
        else if (in_acc)
        begin
            if (data.end_of_response)
            begin
                phase_reg      <= PH_STATUS_START;
                status_reg     <= 10'd0;
                match_pos_reg  <= 3'd0;
                is_chunked_reg <= 1'b0;
                crlf_reg       <= 2'd0;
                remaining_reg  <= '0;
                failed_reg     <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                status_reg     <= status_next;
                match_pos_reg  <= match_pos_next;
                is_chunked_reg <= is_chunked_next;
                crlf_reg       <= crlf_next;
                remaining_reg  <= remaining_next;
                failed_reg     <= failed_next;
            end
        end
    end

    // result queue: up to two writes and one read per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QAW'(out_acc);
            count_reg  <= count_reg + (QAW+1)'(push_n) - (QAW+1)'(out_acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_ptr_reg] <= first_res;
        if (push_n == 2'd2)
            q_reg[wr_ptr_reg + QAW'(1)] <= final_res;
    end

    assign result.valid       = (count_reg != '0);
    assign result.kind        = q_reg[rd_ptr_reg].kind;
    assign result.out_byte    = q_reg[rd_ptr_reg].out_byte;
    assign result.resp_status = q_reg[rd_ptr_reg].resp_status;
    assign result.last        = q_reg[rd_ptr_reg].last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overfilled");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        count_reg == $past(count_reg) + (QAW+1)'($past(push_n)) - (QAW+1)'($past(out_acc)))
        else $error("queue count out of step with pushes and pops");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && data.end_of_response) |=>
        (phase_reg == PH_STATUS_START && !failed_reg && !is_chunked_reg && status_reg == 10'd0))
        else $error("parser state not cleared after end of response");

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg && !(in_acc && data.end_of_response)) |=> failed_reg)
        else $error("failure cleared before end of response");

    a_status_sat: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg <= hrcd_pkg::STATUS_MAX)
        else $error("status code above saturation limit");

endmodule
